[rtl/mr_pkg.sv]
// Shared types and constants for the Miller-Rabin prime tester.
// Used by the controller, the datapath and the modular multiplier.
// No dependencies.
package mr_pkg;

    localparam int MR_NUM_WIDTH = 32;
    localparam int MR_CAND_W    = 32;
    localparam int MR_NUM_BASES = 4;
    localparam int MR_SMALL_LIMIT = 11;

    localparam logic [2:0] MR_BASES [MR_NUM_BASES] = '{3'd2, 3'd3, 3'd5, 3'd7};

    typedef struct packed {
        logic load;
        logic strip;
        logic pow_init;
        logic mul_start;
        logic mul_sq;
        logic acc_load;
        logic ebit_dec;
        logic sq_inc;
        logic base_next;
    } mr_cmd_t;

    typedef struct packed {
        logic below_limit;
        logic small_prime;
        logic m_odd;
        logic e_bit;
        logic ebit_zero;
        logic v_one;
        logic v_nm1;
        logic sq_lt_k;
        logic last_base;
        logic mul_done;
    } mr_sts_t;

endpackage

[rtl/mr_modmul.sv]
// Shift-add modular multiplier: one modular add per cycle, a doubling and a conditional add per bit.
// Depends on mr_pkg.
module mr_modmul import mr_pkg::*; #(
    parameter int NUM_WIDTH = MR_NUM_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] x,
    input  logic [NUM_WIDTH-1:0] y,
    input  logic [NUM_WIDTH-1:0] n,
    output logic                 done,
    output logic [NUM_WIDTH-1:0] prod
);
    localparam int CW = $clog2(NUM_WIDTH);

    logic                 busy_reg, busy_next;
    logic                 phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [NUM_WIDTH-1:0] acc_reg, x_reg, y_reg;
    logic [NUM_WIDTH-1:0] addend;
    logic [NUM_WIDTH:0]   sum;
    logic [NUM_WIDTH:0]   red;
    logic [NUM_WIDTH-1:0] red_low;

    assign addend  = phase_reg ? x_reg : acc_reg;
    assign sum     = {1'b0, acc_reg} + {1'b0, addend};
    assign red     = (sum >= {1'b0, n}) ? (sum - {1'b0, n}) : sum;
    assign red_low = red[NUM_WIDTH-1:0];

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start) begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = CW'(NUM_WIDTH - 1);
        end else if (busy_reg) begin
            phase_next = ~phase_reg;
            if (phase_reg) begin
                if (cnt_reg == '0) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                acc_reg <= red_low;
            end else begin
                if (y_reg[NUM_WIDTH-1]) begin
                    acc_reg <= red_low;
                end
                y_reg <= {y_reg[NUM_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[rtl/mr_datapath.sv]
// Datapath of the prime tester: candidate, odd part, power accumulator and counters.
// Depends on mr_pkg and mr_modmul.
module mr_datapath import mr_pkg::*; #(
    parameter int NUM_WIDTH = MR_NUM_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [MR_CAND_W-1:0] s_candidate,
    input  mr_cmd_t              cmd,
    output mr_sts_t              sts
);
    localparam int KW = $clog2(NUM_WIDTH + 1);
    localparam int EW = $clog2(NUM_WIDTH);

    logic [NUM_WIDTH-1:0] n_reg, m_reg, acc_reg;
    logic [KW-1:0]        k_reg, sq_reg;
    logic [EW-1:0]        ebit_reg;
    logic [1:0]           base_reg;
    logic [NUM_WIDTH-1:0] n_in, n_minus1, base_val, mul_y, prod;
    logic                 mul_done;

    assign n_in     = NUM_WIDTH'(s_candidate);
    assign n_minus1 = n_reg - 1'b1;
    assign base_val = NUM_WIDTH'(MR_BASES[base_reg]);
    assign mul_y    = cmd.mul_sq ? acc_reg : base_val;

    mr_modmul #(.NUM_WIDTH(NUM_WIDTH)) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .x       (acc_reg),
        .y       (mul_y),
        .n       (n_reg),
        .done    (mul_done),
        .prod    (prod)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg    <= n_in;
            m_reg    <= n_in - 1'b1;
            k_reg    <= '0;
            base_reg <= '0;
        end
        if (cmd.strip) begin
            m_reg <= {1'b0, m_reg[NUM_WIDTH-1:1]};
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.pow_init) begin
            acc_reg  <= NUM_WIDTH'(1);
            ebit_reg <= EW'(NUM_WIDTH - 1);
            sq_reg   <= KW'(1);
        end
        if (cmd.acc_load) begin
            acc_reg <= prod;
        end
        if (cmd.ebit_dec) begin
            ebit_reg <= ebit_reg - 1'b1;
        end
        if (cmd.sq_inc) begin
            sq_reg <= sq_reg + 1'b1;
        end
        if (cmd.base_next) begin
            base_reg <= base_reg + 1'b1;
        end
    end

    always_comb begin
        sts.below_limit = n_reg < NUM_WIDTH'(MR_SMALL_LIMIT);
        sts.small_prime = (n_reg == NUM_WIDTH'(MR_BASES[0])) ||
                          (n_reg == NUM_WIDTH'(MR_BASES[1])) ||
                          (n_reg == NUM_WIDTH'(MR_BASES[2])) ||
                          (n_reg == NUM_WIDTH'(MR_BASES[3]));
        sts.m_odd       = m_reg[0];
        sts.e_bit       = m_reg[ebit_reg];
        sts.ebit_zero   = ebit_reg == '0;
        sts.v_one       = acc_reg == NUM_WIDTH'(1);
        sts.v_nm1       = acc_reg == n_minus1;
        sts.sq_lt_k     = sq_reg < k_reg;
        sts.last_base   = base_reg == 2'(MR_NUM_BASES - 1);
        sts.mul_done    = mul_done;
    end

endmodule

[rtl/mr_ctrl.sv]
// Controller state machine of the prime tester and its output word register.
// Depends on mr_pkg; drives the datapath through mr_cmd_t.
module mr_ctrl import mr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output logic    m_is_prime,
    output mr_cmd_t cmd,
    input  mr_sts_t sts
);
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SMALL    = 4'd1;
    localparam logic [3:0] ST_STRIP    = 4'd2;
    localparam logic [3:0] ST_POW_INIT = 4'd3;
    localparam logic [3:0] ST_POW_SQ   = 4'd4;
    localparam logic [3:0] ST_POW_SQ_W = 4'd5;
    localparam logic [3:0] ST_POW_MUL  = 4'd6;
    localparam logic [3:0] ST_POW_MULW = 4'd7;
    localparam logic [3:0] ST_POW_NEXT = 4'd8;
    localparam logic [3:0] ST_TEST     = 4'd9;
    localparam logic [3:0] ST_SQ       = 4'd10;
    localparam logic [3:0] ST_SQ_W     = 4'd11;
    localparam logic [3:0] ST_SQ_CHK   = 4'd12;
    localparam logic [3:0] ST_DONE     = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       verdict_reg, verdict_next;
    logic       m_valid_reg, m_valid_next;
    logic       m_is_prime_reg, m_is_prime_next;
    logic       base_pass;

    assign s_ready = state_reg == ST_IDLE;

    always_comb begin
        cmd             = '0;
        state_next      = state_reg;
        verdict_next    = verdict_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_is_prime_next = m_is_prime_reg;
        base_pass       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SMALL;
                end
            end
            ST_SMALL: begin
                if (sts.below_limit) begin
                    verdict_next = sts.small_prime;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (sts.m_odd) begin
                    state_next = ST_POW_INIT;
                end else begin
                    cmd.strip = 1'b1;
                end
            end
            ST_POW_INIT: begin
                cmd.pow_init = 1'b1;
                state_next   = ST_POW_SQ;
            end
            ST_POW_SQ: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sq    = 1'b1;
                state_next    = ST_POW_SQ_W;
            end
            ST_POW_SQ_W: begin
                if (sts.mul_done) begin
                    cmd.acc_load = 1'b1;
                    state_next   = sts.e_bit ? ST_POW_MUL : ST_POW_NEXT;
                end
            end
            ST_POW_MUL: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_POW_MULW;
            end
            ST_POW_MULW: begin
                if (sts.mul_done) begin
                    cmd.acc_load = 1'b1;
                    state_next   = ST_POW_NEXT;
                end
            end
            ST_POW_NEXT: begin
                if (sts.ebit_zero) begin
                    state_next = ST_TEST;
                end else begin
                    cmd.ebit_dec = 1'b1;
                    state_next   = ST_POW_SQ;
                end
            end
            ST_TEST: begin
                if (sts.v_one || sts.v_nm1) begin
                    base_pass = 1'b1;
                end else if (sts.sq_lt_k) begin
                    state_next = ST_SQ;
                end else begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_SQ: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sq    = 1'b1;
                state_next    = ST_SQ_W;
            end
            ST_SQ_W: begin
                if (sts.mul_done) begin
                    cmd.acc_load = 1'b1;
                    cmd.sq_inc   = 1'b1;
                    state_next   = ST_SQ_CHK;
                end
            end
            ST_SQ_CHK: begin
                if (sts.v_nm1) begin
                    base_pass = 1'b1;
                end else if (sts.sq_lt_k) begin
                    state_next = ST_SQ;
                end else begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_is_prime_next = verdict_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (base_pass) begin
            if (sts.last_base) begin
                verdict_next = 1'b1;
                state_next   = ST_DONE;
            end else begin
                cmd.base_next = 1'b1;
                state_next    = ST_POW_INIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg    <= verdict_next;
        m_is_prime_reg <= m_is_prime_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_is_prime_reg;

endmodule

[rtl/miller_rabin_prime_test_top.sv]
// Channel   | Ports                          | Word
// input     | s_valid, s_ready, s_candidate  | 32-bit unsigned candidate
// result    | m_valid, m_ready, m_is_prime   | 1-bit prime flag
//
// One candidate is worked on at a time; the next is taken once its flag is registered.
// Each modular product comes from the shift-add multiplier, and a candidate needs up to
// 4*(NUM_WIDTH + ones(m) + k - 1) products; values below 11 are decided without any
// product. Reset is synchronous and active low.
// A stalled result word holds in its output register while the next candidate runs.
// Depends on mr_pkg, mr_ctrl and mr_datapath.
module miller_rabin_prime_test_top import mr_pkg::*; #(
    parameter int NUM_WIDTH = MR_NUM_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [MR_CAND_W-1:0] s_candidate,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_prime
);
    mr_cmd_t cmd;
    mr_sts_t sts;

    mr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime),
        .cmd        (cmd),
        .sts        (sts)
    );

    mr_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_candidate (s_candidate),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

[rtl/mr_checker.sv]
// Port-level checks for the prime tester top level, attached by a bind.
// Depends on mr_pkg and miller_rabin_prime_test_top.
module mr_checker import mr_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [MR_CAND_W-1:0] s_candidate,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_is_prime
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result word valid right after reset.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_prime))
        else $error("Stalled result word changed or dropped.");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_candidate))
        else $error("Waiting input word changed or dropped.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input still ready right after a word was taken.");

    a_ready_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("New result word without the input side free.");

endmodule

bind miller_rabin_prime_test_top mr_checker u_mr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_candidate (s_candidate),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_is_prime  (m_is_prime)
);
